// ===== design/fcsr_pkg.sv =====
// Shared constants and controller/datapath handshake types for the circle span block.
`default_nettype none

package fcsr_pkg;

    // Largest radius honored; larger requests are clamped to it.
    localparam int MAX_RADIUS  = 63;
    // Width of a centre coordinate.
    localparam int COORD_BITS  = 12;
    // Width of the radius field on the input word.
    localparam int RADIUS_BITS = 6;
    // Rectangle edges are reported in two's complement, one bit wider than a coordinate.
    localparam int EDGE_BITS   = COORD_BITS + 1;
    // Width of a rectangle size on the output word.
    localparam int SIZE_BITS   = 7;
    // Column and row counters must hold the radius itself, plus one bit of margin.
    localparam int STEP_BITS   = $clog2(MAX_RADIUS + 1) + 1;
    // Squares of the counters.
    localparam int SQ_BITS     = 2 * STEP_BITS;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new circle request
        logic dec_y;   // lower the row counter by one
        logic emit;    // load the output word and advance the column counter
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic shrink;    // row still lies on or outside the circle
        logic done;      // row counter has dropped below the column counter
        logic out_free;  // output register can take a word this cycle
    } t_status;

endpackage

`default_nettype wire

// ===== design/fcsr_dp.sv =====
// Datapath: counters, running squares, span arithmetic and the output register.
`default_nettype none

module fcsr_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [fcsr_pkg::COORD_BITS-1:0]     i_centre_x,
    input  wire logic [fcsr_pkg::COORD_BITS-1:0]     i_centre_y,
    input  wire logic [fcsr_pkg::RADIUS_BITS-1:0]    i_radius,
    input  wire fcsr_pkg::t_cmd                      i_cmd,
    output fcsr_pkg::t_status                        o_status,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_a_x,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_a_y,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_a_w,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_a_h,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_b_x,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_b_y,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_b_w,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_b_h,
    output logic                                     o_last
);

    logic [fcsr_pkg::COORD_BITS-1:0] r_cx;
    logic [fcsr_pkg::COORD_BITS-1:0] r_cy;
    logic [fcsr_pkg::STEP_BITS-1:0]  r_x;
    logic [fcsr_pkg::STEP_BITS-1:0]  r_y;
    logic [fcsr_pkg::SQ_BITS-1:0]    r_xsq;
    logic [fcsr_pkg::SQ_BITS-1:0]    r_ysq;
    logic [fcsr_pkg::SQ_BITS-1:0]    r_rsq;
    logic                            r_valid;

    logic [fcsr_pkg::STEP_BITS-1:0]  w_r_ext;
    logic [fcsr_pkg::STEP_BITS-1:0]  w_r;
    logic [fcsr_pkg::SQ_BITS-1:0]    w_rsq;
    logic [fcsr_pkg::SQ_BITS:0]      w_sum;
    logic [fcsr_pkg::SQ_BITS-1:0]    n_ysq;
    logic [fcsr_pkg::SQ_BITS-1:0]    n_xsq;
    logic                            w_accept;

    // Clamp the radius, then square it once per request.
    assign w_r_ext = fcsr_pkg::STEP_BITS'(i_radius);
    assign w_r     = (w_r_ext > fcsr_pkg::STEP_BITS'(fcsr_pkg::MAX_RADIUS))
                   ? fcsr_pkg::STEP_BITS'(fcsr_pkg::MAX_RADIUS) : w_r_ext;
    assign w_rsq   = fcsr_pkg::SQ_BITS'(w_r) * fcsr_pkg::SQ_BITS'(w_r);

    // Squares are kept up to date incrementally: (y-1)^2 = y^2 - (2y-1), (x+1)^2 = x^2 + 2x+1.
    assign w_sum = (fcsr_pkg::SQ_BITS + 1)'(r_xsq) + (fcsr_pkg::SQ_BITS + 1)'(r_ysq);
    assign n_ysq = r_ysq - (fcsr_pkg::SQ_BITS'(r_y) << 1) + fcsr_pkg::SQ_BITS'(1);
    assign n_xsq = r_xsq + (fcsr_pkg::SQ_BITS'(r_x) << 1) + fcsr_pkg::SQ_BITS'(1);

    assign w_accept = r_valid && !i_stall;

    assign o_status.shrink   = (r_y != '0) && (w_sum >= (fcsr_pkg::SQ_BITS + 1)'(r_rsq));
    assign o_status.done     = (r_y < r_x);
    assign o_status.out_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx  <= i_centre_x;
            r_cy  <= i_centre_y;
            r_x   <= '0;
            r_y   <= w_r;
            r_xsq <= '0;
            r_ysq <= w_rsq;
            r_rsq <= w_rsq;
        end else if (i_cmd.dec_y) begin
            r_y   <= r_y - fcsr_pkg::STEP_BITS'(1);
            r_ysq <= n_ysq;
        end else if (i_cmd.emit) begin
            r_x   <= r_x + fcsr_pkg::STEP_BITS'(1);
            r_xsq <= n_xsq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_rect_a_x <= fcsr_pkg::EDGE_BITS'(r_cx) - fcsr_pkg::EDGE_BITS'(r_x);
            o_rect_a_y <= fcsr_pkg::EDGE_BITS'(r_cy) - fcsr_pkg::EDGE_BITS'(r_y);
            o_rect_a_w <= fcsr_pkg::SIZE_BITS'({r_x, 1'b0});
            o_rect_a_h <= fcsr_pkg::SIZE_BITS'({r_y, 1'b0});
            o_rect_b_x <= fcsr_pkg::EDGE_BITS'(r_cx) - fcsr_pkg::EDGE_BITS'(r_y);
            o_rect_b_y <= fcsr_pkg::EDGE_BITS'(r_cy) - fcsr_pkg::EDGE_BITS'(r_x);
            o_rect_b_w <= fcsr_pkg::SIZE_BITS'({r_y, 1'b0});
            o_rect_b_h <= fcsr_pkg::SIZE_BITS'({r_x, 1'b0});
            o_last     <= (r_y < r_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (w_accept) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== design/fcsr_ctrl.sv =====
// Controller: sequences row decrements and pair emission for one circle at a time.
`default_nettype none

module fcsr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire fcsr_pkg::t_status i_status,
    output fcsr_pkg::t_cmd         o_cmd,
    output logic                   o_busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.dec_y = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.shrink) begin
                    o_cmd.dec_y = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.done) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == ST_SCAN);

endmodule

`default_nettype wire

// ===== design/filled_circle_span_rects.sv =====
// Top level of the filled circle span rectangle generator.
// A request is loaded, the row counter is lowered until the row fits (not at all for a zero
// radius), and the first pair is then registered; each later pair follows its own row decrements.
// Throughput: one decrement or one pair per scan cycle, plus any cycles the output sits stalled;
// at radius 63 a circle yields 46 pairs after 19 row decrements.
// A new request is taken the cycle after the last pair is registered.
// Reset is synchronous and active low; it idles the controller and empties the output register.
`default_nettype none

module filled_circle_span_rects (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Request channel.
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [fcsr_pkg::COORD_BITS-1:0]     i_centre_x,
    input  wire logic [fcsr_pkg::COORD_BITS-1:0]     i_centre_y,
    input  wire logic [fcsr_pkg::RADIUS_BITS-1:0]    i_radius,
    // Result channel.
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_a_x,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_a_y,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_a_w,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_a_h,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_b_x,
    output logic signed [fcsr_pkg::EDGE_BITS-1:0]    o_rect_b_y,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_b_w,
    output logic        [fcsr_pkg::SIZE_BITS-1:0]    o_rect_b_h,
    output logic                                     o_last
);

    // The controller walks the column counter upward. In every scan cycle it either lowers
    // the row counter (while the row still reaches the circle boundary and is above zero)
    // or, once the row fits and the output register is free, loads one rectangle pair into the
    // output register and steps the column. The pair where the row falls below the column is the last one.
    fcsr_pkg::t_cmd    w_cmd;
    fcsr_pkg::t_status w_status;
    logic              w_busy;

    // Requests are refused only while a circle is being scanned. A finished word may
    // still sit in the output register when the next request is taken.
    assign o_stall = w_busy;

    fcsr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    fcsr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_centre_x (i_centre_x),
        .i_centre_y (i_centre_y),
        .i_radius   (i_radius),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_rect_a_x (o_rect_a_x),
        .o_rect_a_y (o_rect_a_y),
        .o_rect_a_w (o_rect_a_w),
        .o_rect_a_h (o_rect_a_h),
        .o_rect_b_x (o_rect_b_x),
        .o_rect_b_y (o_rect_b_y),
        .o_rect_b_w (o_rect_b_w),
        .o_rect_b_h (o_rect_b_h),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

// ===== design/fcsr_checker.sv =====
// Port-level checks for the circle span block, bound to its top level.
`default_nettype none

module fcsr_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic                                o_stall,
    input  wire logic                                o_valid,
    input  wire logic                                i_stall,
    input  wire logic signed [fcsr_pkg::EDGE_BITS-1:0] o_rect_a_x,
    input  wire logic signed [fcsr_pkg::EDGE_BITS-1:0] o_rect_b_x,
    input  wire logic        [fcsr_pkg::SIZE_BITS-1:0] o_rect_a_w,
    input  wire logic        [fcsr_pkg::SIZE_BITS-1:0] o_rect_a_h,
    input  wire logic        [fcsr_pkg::SIZE_BITS-1:0] o_rect_b_w,
    input  wire logic        [fcsr_pkg::SIZE_BITS-1:0] o_rect_b_h,
    input  wire logic                                o_last
);

    // A stalled word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rect_a_x) && $stable(o_rect_b_x)
            && $stable(o_last))
        else $error("stalled output word changed");

    // The second rectangle is the octant mirror of the first.
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rect_a_w == o_rect_b_h) && (o_rect_a_h == o_rect_b_w))
        else $error("mirrored rectangle sizes disagree");

    // Sizes are twice a counter, so always even.
    a_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_rect_a_w[0] && !o_rect_a_h[0])
        else $error("odd rectangle size");

    // A taken request keeps the request side stalled while the circle is scanned.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request side not stalled after a request");

    // The closing pair is the one where the row dropped below the column.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_rect_a_h < o_rect_a_w)
        else $error("last pair does not close the octant");

endmodule

bind filled_circle_span_rects fcsr_checker u_fcsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_rect_a_x (o_rect_a_x),
    .o_rect_b_x (o_rect_b_x),
    .o_rect_a_w (o_rect_a_w),
    .o_rect_a_h (o_rect_a_h),
    .o_rect_b_w (o_rect_b_w),
    .o_rect_b_h (o_rect_b_h),
    .o_last     (o_last)
);

`default_nettype wire

// ===== tb/sv/fcsr_span_monitor.sv =====
// Channel monitor that predicts and checks the rectangle pairs of the circle span block.
`timescale 1ns / 1ps

module fcsr_span_monitor
    import fcsr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_req_valid,
    input  wire logic                   i_req_stall,
    input  wire logic [COORD_BITS-1:0]  i_centre_x,
    input  wire logic [COORD_BITS-1:0]  i_centre_y,
    input  wire logic [RADIUS_BITS-1:0] i_radius,
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_stall,
    input  wire logic [EDGE_BITS-1:0]   i_rect_a_x,
    input  wire logic [EDGE_BITS-1:0]   i_rect_a_y,
    input  wire logic [SIZE_BITS-1:0]   i_rect_a_w,
    input  wire logic [SIZE_BITS-1:0]   i_rect_a_h,
    input  wire logic [EDGE_BITS-1:0]   i_rect_b_x,
    input  wire logic [EDGE_BITS-1:0]   i_rect_b_y,
    input  wire logic [SIZE_BITS-1:0]   i_rect_b_w,
    input  wire logic [SIZE_BITS-1:0]   i_rect_b_h,
    input  wire logic                   i_last,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic [EDGE_BITS-1:0] a_x;
        logic [EDGE_BITS-1:0] a_y;
        logic [SIZE_BITS-1:0] a_w;
        logic [SIZE_BITS-1:0] a_h;
        logic [EDGE_BITS-1:0] b_x;
        logic [EDGE_BITS-1:0] b_y;
        logic [SIZE_BITS-1:0] b_w;
        logic [SIZE_BITS-1:0] b_h;
        logic                 last;
    } t_span_pair;

    t_span_pair expected_spans[$];
    int         mismatch_count = 0;
    int         pending_count = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    // Walks the columns of one circle and queues every rectangle pair it yields.
    task automatic queue_spans(input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic [RADIUS_BITS-1:0] r);
        int         rad;
        int         rsq;
        int         col;
        int         row;
        bit         finished;
        t_span_pair pair;
        rad = (int'(r) > MAX_RADIUS) ? MAX_RADIUS : int'(r);
        rsq = rad * rad;
        row = rad;
        col = 0;
        finished = 1'b0;
        while (!finished) begin
            // The row never drops below zero, which ends small circles.
            while (row > 0 && row * row + col * col >= rsq) begin
                row--;
            end
            finished  = (row < col);
            pair.a_x  = EDGE_BITS'(int'(cx) - col);
            pair.a_y  = EDGE_BITS'(int'(cy) - row);
            pair.a_w  = SIZE_BITS'(2 * col);
            pair.a_h  = SIZE_BITS'(2 * row);
            pair.b_x  = EDGE_BITS'(int'(cx) - row);
            pair.b_y  = EDGE_BITS'(int'(cy) - col);
            pair.b_w  = SIZE_BITS'(2 * row);
            pair.b_h  = SIZE_BITS'(2 * col);
            pair.last = finished;
            expected_spans.push_back(pair);
            col++;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: mismatch on %s, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_span_pair want;
        if (!i_rst_n) begin
            expected_spans.delete();
        end else begin
            // Results are checked before a request of the same edge is queued, so a
            // stray word can never be matched against a circle taken at that edge.
            if (i_res_valid && !i_res_stall) begin
                if (expected_spans.size() == 0) begin
                    $display(
                        "%0t ns: extra word, expected none, actual a=(%0d,%0d,%0d,%0d) last=%0b",
                        $time, $signed(i_rect_a_x), $signed(i_rect_a_y),
                        i_rect_a_w, i_rect_a_h, i_last);
                    mismatch_count++;
                end else begin
                    want = expected_spans.pop_front();
                    check_field("rect_a_x", $signed(want.a_x), $signed(i_rect_a_x));
                    check_field("rect_a_y", $signed(want.a_y), $signed(i_rect_a_y));
                    check_field("rect_a_w", want.a_w, i_rect_a_w);
                    check_field("rect_a_h", want.a_h, i_rect_a_h);
                    check_field("rect_b_x", $signed(want.b_x), $signed(i_rect_b_x));
                    check_field("rect_b_y", $signed(want.b_y), $signed(i_rect_b_y));
                    check_field("rect_b_w", want.b_w, i_rect_b_w);
                    check_field("rect_b_h", want.b_h, i_rect_b_h);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_req_valid && !i_req_stall) begin
                queue_spans(i_centre_x, i_centre_y, i_radius);
            end
        end
        pending_count = expected_spans.size();
    end

endmodule

// ===== tb/sv/tb_filled_circle_span_rects.sv =====
// Top of the circle span testbench: clock, reset, circle stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_filled_circle_span_rects;
    import fcsr_pkg::*;

    // Every input of the block starts at a known value, reset asserted.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic [COORD_BITS-1:0]         i_centre_x = '0;
    logic [COORD_BITS-1:0]         i_centre_y = '0;
    logic [RADIUS_BITS-1:0]        i_radius = '0;
    logic                          i_stall = 1'b1;

    logic                          o_stall;
    logic                          o_valid;
    logic signed [EDGE_BITS-1:0]   o_rect_a_x;
    logic signed [EDGE_BITS-1:0]   o_rect_a_y;
    logic        [SIZE_BITS-1:0]   o_rect_a_w;
    logic        [SIZE_BITS-1:0]   o_rect_a_h;
    logic signed [EDGE_BITS-1:0]   o_rect_b_x;
    logic signed [EDGE_BITS-1:0]   o_rect_b_y;
    logic        [SIZE_BITS-1:0]   o_rect_b_w;
    logic        [SIZE_BITS-1:0]   o_rect_b_h;
    logic                          o_last;

    int error_count;
    int spans_pending;

    // Percent of cycles in which the sender holds back a word and the receiver stalls.
    int send_idle_pct = 30;
    int recv_stall_pct = 64;

    always #6 i_clk = ~i_clk;

    filled_circle_span_rects dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_centre_x (i_centre_x),
        .i_centre_y (i_centre_y),
        .i_radius   (i_radius),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rect_a_x (o_rect_a_x),
        .o_rect_a_y (o_rect_a_y),
        .o_rect_a_w (o_rect_a_w),
        .o_rect_a_h (o_rect_a_h),
        .o_rect_b_x (o_rect_b_x),
        .o_rect_b_y (o_rect_b_y),
        .o_rect_b_w (o_rect_b_w),
        .o_rect_b_h (o_rect_b_h),
        .o_last     (o_last)
    );

    // The monitor sees both channels exactly as the block does and reports back a
    // running failure count and the number of rectangle pairs still owed.
    fcsr_span_monitor span_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_centre_x  (i_centre_x),
        .i_centre_y  (i_centre_y),
        .i_radius    (i_radius),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_rect_a_x  (o_rect_a_x),
        .i_rect_a_y  (o_rect_a_y),
        .i_rect_a_w  (o_rect_a_w),
        .i_rect_a_h  (o_rect_a_h),
        .i_rect_b_x  (o_rect_b_x),
        .i_rect_b_y  (o_rect_b_y),
        .i_rect_b_w  (o_rect_b_w),
        .i_rect_b_h  (o_rect_b_h),
        .i_last      (o_last),
        .o_errors    (error_count),
        .o_pending   (spans_pending)
    );

    // The receiver decides its stall once per falling edge, independent of the
    // result valid, so a single assignment lands in each time step.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Offers one circle request word. Idle cycles come first, with valid low; the
    // word then stays put until the block takes it at a rising edge. The task
    // returns at the falling edge after acceptance, where the next call decides
    // whether valid drops or carries the next word, never both.
    task automatic send_circle(input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic [RADIUS_BITS-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_centre_x <= cx;
        i_centre_y <= cy;
        i_radius   <= r;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Holds the request channel quiet until every owed pair has come out.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (spans_pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Random circle: the centre sits near either border now and then so that
    // edges wrap below zero or land at the top of the coordinate range.
    task automatic send_random_circle();
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        cx = COORD_BITS'($urandom);
        cy = COORD_BITS'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                cx = COORD_BITS'($urandom_range(0, 63));
                cy = COORD_BITS'($urandom_range(0, 63));
            end
            1: begin
                cx = COORD_BITS'($urandom_range(4032, 4095));
                cy = COORD_BITS'($urandom_range(4032, 4095));
            end
            default: begin
            end
        endcase
        send_circle(cx, cy, RADIUS_BITS'($urandom_range(0, 63)));
    endtask

    initial begin
        // Synchronous reset is held from time zero, then released once at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. A zero radius yields just the two degenerate pairs, and
        // radii up to three rely on the row stopping at zero to terminate.
        send_circle(12'd0, 12'd0, 6'd0);
        send_circle(12'd4095, 12'd4095, 6'd0);
        send_circle(12'd100, 12'd200, 6'd1);
        send_circle(12'd300, 12'd400, 6'd2);
        send_circle(12'd500, 12'd600, 6'd3);
        send_circle(12'd700, 12'd800, 6'd4);
        // The largest radius around the origin drives both left and top edges
        // well below zero; at the far corner the edges stay near the top.
        send_circle(12'd0, 12'd0, 6'd63);
        send_circle(12'd4095, 12'd4095, 6'd63);
        send_circle(12'd2048, 12'd2048, 6'd63);
        send_circle(12'd10, 12'd4000, 6'd40);
        send_circle(12'hAAA, 12'h555, 6'h2A);
        send_circle(12'h555, 12'hAAA, 6'h15);
        send_circle(12'd1, 12'd2, 6'd62);
        send_circle(12'd1234, 12'd3210, 6'd5);
        send_circle(12'd63, 12'd31, 6'd32);

        // Sender pauses here until the block has owed nothing for a moment.
        wait_for_drain();

        // First random phase: sender idles less than the receiver stalls.
        repeat (60) send_random_circle();
        wait_for_drain();

        // Second phase swaps the roles.
        send_idle_pct  = 64;
        recv_stall_pct = 30;
        repeat (60) send_random_circle();
        wait_for_drain();

        // Last phase runs both sides flat out, back-to-back circles included.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (60) send_random_circle();
        wait_for_drain();

        // Allow a few circle times for any late or extra word to show up.
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && spans_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of every phase.
    initial begin
        #6000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
